// ----- sv/csr_pkg.sv -----
`default_nettype none
// ============================================================================
// csr_pkg
// Shared types and constants of the canvas shape rasterizer.
// ============================================================================
package csr_pkg;

    localparam int COORD_W   = 15;
    localparam int ROOT_IN_W = 22;
    localparam int ROOT_W    = 11;

    localparam logic [ROOT_IN_W-1:0] ROOT_BIT0 = ROOT_IN_W'(1) << (ROOT_IN_W - 2);

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        REQ_RECT   = 2'd0,
        REQ_LINE   = 2'd1,
        REQ_CIRCLE = 2'd2,
        REQ_READ   = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_GRID  = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_req_kind          req_type;
        logic signed [11:0] x_a;
        logic signed [11:0] y_a;
        logic signed [11:0] x_b;
        logic signed [11:0] y_b;
        logic [10:0]        circle_reach;
        logic [7:0]         draw_char;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [7:0] cell_value;
    } t_rsp;

    typedef struct packed {
        logic start;
        t_req req;
    } t_gen_cmd;

    typedef struct packed {
        logic   valid;
        t_coord x;
        t_coord y;
        logic   done;
    } t_plot;

endpackage
`default_nettype wire

// ----- sv/csr_ram.sv -----
`default_nettype none
// ============================================================================
// csr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- sv/csr_isqrt.sv -----
`default_nettype none
// ============================================================================
// csr_isqrt
// Iterative integer square root with remainder, settling the result bits from the top down.
// ============================================================================
module csr_isqrt
    import csr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [ROOT_IN_W-1:0] i_value,
    output logic                      o_done,
    output logic [ROOT_W-1:0]         o_root,
    output logic [ROOT_W:0]           o_rem
);

    logic [ROOT_IN_W-1:0] r_v, n_v;
    logic [ROOT_IN_W-1:0] r_res, n_res;
    logic [ROOT_IN_W-1:0] r_bit, n_bit;
    logic                 r_done, n_done;
    logic [ROOT_IN_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_comb begin
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        n_done = 1'b0;
        if (i_start) begin
            n_v   = i_value;
            n_res = '0;
            n_bit = ROOT_BIT0;
        end else if (r_bit != '0) begin
            if (r_v >= w_trial) begin
                n_v   = r_v - w_trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit  = r_bit >> 2;
            n_done = (r_bit == ROOT_IN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_bit  <= n_bit;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
    assign o_rem  = r_v[ROOT_W:0];

endmodule
`default_nettype wire

// ----- sv/csr_plotter.sv -----
`default_nettype none
// ============================================================================
// csr_plotter
// Shape sequencer: emits one cell coordinate per cycle for rectangles,
// lines and circles, pausing for the square root of each circle column.
// ============================================================================
module csr_plotter
    import csr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_gen_cmd i_cmd,
    output t_plot         o_plot
);

    typedef enum logic [7:0] {
        G_IDLE  = 8'b0000_0001,
        G_RUN   = 8'b0000_0010,
        G_LINE  = 8'b0000_0100,
        G_CSQ   = 8'b0000_1000,
        G_CROOT = 8'b0001_0000,
        G_CPLOT = 8'b0010_0000,
        G_TIPS  = 8'b0100_0000,
        G_FIN   = 8'b1000_0000
    } t_gstate;

    localparam int ACC_W = 15;

    t_gstate r_state, n_state;

    logic signed [11:0] r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    logic [1:0]         r_seg, n_seg;
    logic signed [11:0] r_pos, n_pos;

    logic signed [11:0]      r_lx, n_lx, r_ly, n_ly, r_lx2, n_lx2;
    logic [11:0]             r_dx, n_dx, r_m, n_m;
    logic                    r_neg, n_neg;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    logic [10:0]          r_reach, n_reach;
    logic [10:0]          r_r, n_r;
    logic [10:0]          r_i, n_i;
    logic [ROOT_IN_W-1:0] r_v, n_v;
    t_coord               r_cur, n_cur, r_rd, n_rd;
    logic [11:0]          r_j, n_j, r_last, n_last;
    logic [1:0]           r_q, n_q;

    logic                 w_root_start;
    logic [ROOT_IN_W-1:0] w_root_value;
    logic                 w_root_done;
    logic [ROOT_W-1:0]    w_root;
    logic [ROOT_W:0]      w_rem;
    logic                 w_adv;

    logic signed [11:0] w_xmin, w_xmax, w_ymin, w_ymax;
    logic               w_swap;
    logic signed [11:0] w_lx1, w_ly1, w_lx2, w_ly2;
    logic signed [12:0] w_dy, w_dx13;
    logic               w_cont;
    logic signed [11:0] w_run_end;

    t_coord w_cx, w_cy, w_ie, w_je, w_reach_e;
    t_coord w_fl, w_rd, w_diff, w_up, w_dn;

    assign w_xmin = (i_cmd.req.x_a < i_cmd.req.x_b) ? i_cmd.req.x_a : i_cmd.req.x_b;
    assign w_xmax = (i_cmd.req.x_a < i_cmd.req.x_b) ? i_cmd.req.x_b : i_cmd.req.x_a;
    assign w_ymin = (i_cmd.req.y_a < i_cmd.req.y_b) ? i_cmd.req.y_a : i_cmd.req.y_b;
    assign w_ymax = (i_cmd.req.y_a < i_cmd.req.y_b) ? i_cmd.req.y_b : i_cmd.req.y_a;
    assign w_swap = i_cmd.req.x_a > i_cmd.req.x_b;
    assign w_lx1  = w_swap ? i_cmd.req.x_b : i_cmd.req.x_a;
    assign w_ly1  = w_swap ? i_cmd.req.y_b : i_cmd.req.y_a;
    assign w_lx2  = w_swap ? i_cmd.req.x_a : i_cmd.req.x_b;
    assign w_ly2  = w_swap ? i_cmd.req.y_a : i_cmd.req.y_b;
    assign w_dy   = 13'(w_ly2) - 13'(w_ly1);
    assign w_dx13 = 13'(w_lx2) - 13'(w_lx1);

    assign w_cont    = r_neg ? (r_acc > 0) : (r_acc >= $signed({3'b000, r_dx}));
    assign w_run_end = r_seg[1] ? r_y1 : r_x1;

    assign w_cx      = COORD_W'(r_x0);
    assign w_cy      = COORD_W'(r_y0);
    assign w_ie      = COORD_W'($signed({1'b0, r_i}));
    assign w_je      = COORD_W'($signed({1'b0, r_j}));
    assign w_reach_e = COORD_W'($signed({1'b0, r_reach}));
    assign w_fl      = w_cy + COORD_W'($signed({1'b0, w_root}));
    assign w_rd      = w_fl + ((w_rem > {1'b0, w_root}) ? COORD_W'(1) : COORD_W'(0));
    assign w_diff    = r_cur - w_fl;
    assign w_up      = r_cur - w_je;
    assign w_dn      = w_cy + w_cy - r_cur + w_je;

    csr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_root_value),
        .o_done  (w_root_done),
        .o_root  (w_root),
        .o_rem   (w_rem)
    );

    always_comb begin
        n_state = r_state;
        n_x0 = r_x0; n_x1 = r_x1; n_y0 = r_y0; n_y1 = r_y1;
        n_seg = r_seg; n_pos = r_pos;
        n_lx = r_lx; n_ly = r_ly; n_lx2 = r_lx2; n_dx = r_dx; n_m = r_m;
        n_neg = r_neg; n_acc = r_acc;
        n_reach = r_reach; n_r = r_r; n_i = r_i; n_v = r_v;
        n_cur = r_cur; n_rd = r_rd; n_j = r_j; n_last = r_last; n_q = r_q;
        w_root_start = 1'b0;
        w_root_value = r_v;
        w_adv        = 1'b0;
        o_plot       = '0;
        unique case (r_state)
            G_IDLE: begin
                if (i_cmd.start) begin
                    unique case (i_cmd.req.req_type)
                        REQ_RECT: begin
                            n_x0 = w_xmin; n_x1 = w_xmax; n_y0 = w_ymin; n_y1 = w_ymax;
                            n_seg = 2'd0;
                            n_pos = w_xmin;
                            n_state = G_RUN;
                        end
                        REQ_LINE: begin
                            if (i_cmd.req.x_a == i_cmd.req.x_b) begin
                                n_x0 = i_cmd.req.x_a; n_x1 = i_cmd.req.x_a;
                                n_y0 = w_ymin; n_y1 = w_ymax;
                                n_seg = 2'd3;
                                n_pos = w_ymin;
                                n_state = G_RUN;
                            end else begin
                                n_lx  = w_lx1;
                                n_ly  = w_ly1;
                                n_lx2 = w_lx2;
                                n_dx  = w_dx13[11:0];
                                n_neg = w_dy < 0;
                                n_m   = (w_dy < 0) ? 12'(-w_dy) : w_dy[11:0];
                                n_acc = '0;
                                n_state = G_LINE;
                            end
                        end
                        REQ_CIRCLE: begin
                            n_x0    = i_cmd.req.x_a;
                            n_y0    = i_cmd.req.y_a;
                            n_reach = i_cmd.req.circle_reach;
                            n_r     = i_cmd.req.circle_reach - 11'd1;
                            n_q     = '0;
                            n_state = (i_cmd.req.circle_reach == '0) ? G_TIPS : G_CSQ;
                        end
                        REQ_READ: begin
                            n_state = G_FIN;
                        end
                    endcase
                end
            end
            G_RUN: begin
                o_plot.valid = 1'b1;
                unique case (r_seg)
                    2'd0: begin o_plot.x = COORD_W'(r_pos); o_plot.y = COORD_W'(r_y1); end
                    2'd1: begin o_plot.x = COORD_W'(r_pos); o_plot.y = COORD_W'(r_y0); end
                    2'd2: begin o_plot.x = COORD_W'(r_x1);  o_plot.y = COORD_W'(r_pos); end
                    2'd3: begin o_plot.x = COORD_W'(r_x0);  o_plot.y = COORD_W'(r_pos); end
                endcase
                if (r_pos == w_run_end) begin
                    if (r_seg == 2'd3) begin
                        n_state = G_FIN;
                    end else begin
                        n_seg = r_seg + 2'd1;
                        n_pos = n_seg[1] ? r_y0 : r_x0;
                    end
                end else begin
                    n_pos = r_pos + 12'sd1;
                end
            end
            G_LINE: begin
                o_plot.valid = 1'b1;
                o_plot.x     = COORD_W'(r_lx);
                o_plot.y     = COORD_W'(r_ly);
                if (w_cont) begin
                    n_ly  = r_neg ? (r_ly - 12'sd1) : (r_ly + 12'sd1);
                    n_acc = r_acc - $signed({3'b000, r_dx});
                end else if (r_lx == r_lx2) begin
                    n_state = G_FIN;
                end else begin
                    n_lx  = r_lx + 12'sd1;
                    n_acc = r_acc + $signed({3'b000, r_m});
                end
            end
            G_CSQ: begin
                n_v          = ROOT_IN_W'(r_r) * ROOT_IN_W'(r_r);
                n_i          = '0;
                n_cur        = w_cy + COORD_W'($signed({1'b0, r_r}));
                w_root_start = 1'b1;
                w_root_value = n_v;
                n_state      = G_CROOT;
            end
            G_CROOT: begin
                if (w_root_done) begin
                    if (r_i != '0) begin
                        n_rd    = w_rd;
                        n_last  = (w_diff < 1) ? 12'd0 : 12'(w_diff - COORD_W'(1));
                        n_j     = '0;
                        n_q     = '0;
                        n_state = G_CPLOT;
                    end else begin
                        n_cur = w_rd;
                        w_adv = 1'b1;
                    end
                end
            end
            G_CPLOT: begin
                o_plot.valid = 1'b1;
                o_plot.x     = r_q[0] ? (w_cx - w_ie) : (w_cx + w_ie);
                o_plot.y     = r_q[1] ? w_dn : w_up;
                n_q          = r_q + 2'd1;
                if (r_q == 2'd3) begin
                    if (r_j == r_last) begin
                        n_cur = r_rd;
                        w_adv = 1'b1;
                    end else begin
                        n_j = r_j + 12'd1;
                    end
                end
            end
            G_TIPS: begin
                o_plot.valid = 1'b1;
                unique case (r_q)
                    2'd0: begin o_plot.x = w_cx;             o_plot.y = w_cy + w_reach_e; end
                    2'd1: begin o_plot.x = w_cx + w_reach_e; o_plot.y = w_cy;             end
                    2'd2: begin o_plot.x = w_cx;             o_plot.y = w_cy - w_reach_e; end
                    2'd3: begin o_plot.x = w_cx - w_reach_e; o_plot.y = w_cy;             end
                endcase
                n_q = r_q + 2'd1;
                if (r_q == 2'd3) begin
                    n_state = G_FIN;
                end
            end
            G_FIN: begin
                o_plot.done = 1'b1;
                n_state     = G_IDLE;
            end
            default: begin
                n_state = G_IDLE;
            end
        endcase
        if (w_adv) begin
            if (r_i == r_r) begin
                n_q     = '0;
                n_state = G_TIPS;
            end else begin
                n_i          = r_i + 11'd1;
                n_v          = r_v - ROOT_IN_W'({r_i, 1'b1});
                w_root_start = 1'b1;
                w_root_value = n_v;
                n_state      = G_CROOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x0 <= n_x0; r_x1 <= n_x1; r_y0 <= n_y0; r_y1 <= n_y1;
        r_seg <= n_seg; r_pos <= n_pos;
        r_lx <= n_lx; r_ly <= n_ly; r_lx2 <= n_lx2; r_dx <= n_dx; r_m <= n_m;
        r_neg <= n_neg; r_acc <= n_acc;
        r_reach <= n_reach; r_r <= n_r; r_i <= n_i; r_v <= n_v;
        r_cur <= n_cur; r_rd <= n_rd; r_j <= n_j; r_last <= n_last; r_q <= n_q;
    end

    a_root_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_start |-> (r_state == G_CSQ || r_state == G_CROOT || r_state == G_CPLOT))
        else $error("root started from wrong state");

    a_done_then_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_plot.done |=> r_state == G_IDLE)
        else $error("sequencer not idle after done");

endmodule
`default_nettype wire

// ----- sv/canvas_shape_rasterizer.sv -----
`default_nettype none
// ============================================================================
// canvas_shape_rasterizer
// Character canvas plotter: draws rectangles, lines and circles into a
// square byte canvas and reads single cells.
// ============================================================================
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_in_data  (t_req)
//  out       output     o_out_valid / i_out_stall    o_out_data (t_rsp)
//  cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
//  after reset the canvas is cleared, one cell a cycle, all CANVAS_SIZE*CANVAS_SIZE
//  cells, with input stalled; cfg writes are taken meanwhile
//  a draw steps through every plotted cell (clipped cells too);
//  a circle also waits on the square root unit for each column
//  a read goes through the canvas memory read port
//  one item at a time; a finished result waits in the output register
// ============================================================================
module canvas_shape_rasterizer
    import csr_pkg::*;
#(
    parameter int CANVAS_SIZE = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_req        i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_rsp             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [10:0] i_cfg_wdata
);

    localparam int DEPTH  = CANVAS_SIZE * CANVAS_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CB     = $clog2(CANVAS_SIZE);
    localparam logic signed [COORD_W-1:0] SIZE_C = COORD_W'(CANVAS_SIZE);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DRAW  = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [10:0]       r_grid_w, r_grid_h;
    logic [7:0]        r_pen, n_pen;
    t_rsp              r_rsp, n_rsp;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    t_gen_cmd          w_cmd;
    t_plot             w_plot;
    logic              w_accept, w_grid_set, w_rd_outside, w_rd_in_store, w_plot_in;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [7:0]        w_wdata, w_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_grid_set  = (r_grid_w != '0) && (r_grid_h != '0);
    assign w_rd_outside = i_in_data.x_a[11] || i_in_data.y_a[11]
                          || (i_in_data.x_a[10:0] >= r_grid_w)
                          || (i_in_data.y_a[10:0] >= r_grid_h);
    assign w_rd_in_store = (i_in_data.x_a[10:0] < 11'(CANVAS_SIZE))
                           && (i_in_data.y_a[10:0] < 11'(CANVAS_SIZE));

    assign w_cmd.start = w_accept && w_grid_set && (i_in_data.req_type != REQ_READ);
    assign w_cmd.req   = i_in_data;

    csr_plotter u_plotter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_plot  (w_plot)
    );

    assign w_plot_in = w_plot.valid && (w_plot.x >= 0) && (w_plot.x < SIZE_C)
                       && (w_plot.y >= 0) && (w_plot.y < SIZE_C);

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else begin
            w_we    = w_plot_in;
            w_waddr = ADDR_W'(w_plot.y[CB-1:0] * CANVAS_SIZE) + ADDR_W'(w_plot.x[CB-1:0]);
            w_wdata = r_pen;
        end
    end

    assign w_raddr = ADDR_W'(i_in_data.y_a[CB-1:0] * CANVAS_SIZE)
                     + ADDR_W'(i_in_data.x_a[CB-1:0]);

    csr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pen       = r_pen;
        n_rsp       = r_rsp;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_rsp.status     = ST_DONE;
                    n_rsp.cell_value = '0;
                    n_state          = S_DONE;
                    if (!w_grid_set) begin
                        n_rsp.status = ST_NO_GRID;
                    end else begin
                        n_pen = i_in_data.draw_char;
                        if (i_in_data.req_type != REQ_READ) begin
                            n_state = S_DRAW;
                        end else if (w_rd_outside) begin
                            n_rsp.status = ST_OUTSIDE;
                        end else if (w_rd_in_store) begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_DRAW: begin
                if (w_plot.done) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_rsp.cell_value = w_rdata;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_rsp;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_grid_w    <= '0;
            r_grid_h    <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                priority if (i_cfg_idx == CFG_GRID_WIDTH) begin
                    r_grid_w <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_GRID_HEIGHT) begin
                    r_grid_h <= i_cfg_wdata;
                end
            end
        end
        r_pen <= n_pen;
        r_rsp <= n_rsp;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_plot_in_draw : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_plot.valid |-> r_state == S_DRAW)
        else $error("plot outside of a draw");

    a_out_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    a_read_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> $past(r_state == S_IDLE))
        else $error("read wait without accepted read");

endmodule
`default_nettype wire

// ----- tb/canvas_shape_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// canvas_shape_rasterizer_tb
// Self-checking bench for the canvas plotter. It keeps its own copy of the
// canvas and grid size, predicts the status and cell byte of every request,
// and checks each response transfer in order. Directed shapes and reads come
// first, then random requests over several grid sizes, with random idling
// and back-pressure on both channels.
// ============================================================================
module canvas_shape_rasterizer_tb;
    import csr_pkg::*;

    localparam int SIDE        = 256;
    localparam int CYCLE_LIMIT = 8000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_rsp        o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [10:0] i_cfg_wdata;

    canvas_shape_rasterizer #(.CANVAS_SIZE(SIDE)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [7:0] pix [SIDE*SIDE];
    int         grid_w;
    int         grid_h;
    t_rsp       expected_rsp [$];
    int         errors;
    int         cycles;
    bit         idle_on;
    bit         hold_go;
    int         hold_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // canvas prediction
    // ------------------------------------------------------------------
    function automatic void plot_cell(int x, int y, logic [7:0] ch);
        if (x >= 0 && y >= 0 && x < SIDE && y < SIDE)
            pix[y*SIDE + x] = ch;
    endfunction

    function automatic int unsigned int_root(int unsigned v);
        int unsigned res;
        int unsigned b;
        res = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void rect_outline(int xa, int ya, int xb, int yb, logic [7:0] ch);
        int x0, x1, y0, y1;
        x0 = xa < xb ? xa : xb;
        x1 = xa < xb ? xb : xa;
        y0 = ya < yb ? ya : yb;
        y1 = ya < yb ? yb : ya;
        for (int i = x0; i <= x1; i++) begin
            plot_cell(i, y1, ch);
            plot_cell(i, y0, ch);
        end
        for (int i = y0; i <= y1; i++) begin
            plot_cell(x1, i, ch);
            plot_cell(x0, i, ch);
        end
    endfunction

    function automatic void line_cells(int xa, int ya, int xb, int yb, logic [7:0] ch);
        int x1, y1, x2, y2, dx, dy, cur, fy, k;
        if (xa > xb) begin
            x1 = xb; y1 = yb; x2 = xa; y2 = ya;
        end else begin
            x1 = xa; y1 = ya; x2 = xb; y2 = yb;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) begin
            for (int i = (y1 < y2 ? y1 : y2); i <= (y1 < y2 ? y2 : y1); i++)
                plot_cell(x1, i, ch);
        end else if (dy == 0) begin
            for (int i = x1; i <= x2; i++)
                plot_cell(i, y1, ch);
        end else begin
            cur = y1;
            for (int i = x1; i <= x2; i++) begin
                k = i - x1;
                if (dy > 0) begin
                    fy = y1 + (dy * k) / dx;
                    for (int j = cur; j <= fy; j++) plot_cell(i, j, ch);
                end else begin
                    fy = y1 - ((-dy) * k + dx - 1) / dx;
                    for (int j = fy; j <= cur; j++) plot_cell(i, j, ch);
                end
                cur = fy;
            end
        end
    endfunction

    function automatic void circle_cells(int cx, int cy, int reach, logic [7:0] ch);
        int r, cur, s, fl, rd, cnt, up, dn;
        int unsigned v;
        r = reach - 1;
        cur = cy + r;
        for (int i = 0; i <= r; i++) begin
            v = r*r - i*i;
            s = int_root(v);
            fl = cy + s;
            rd = fl + ((v - s*s > s) ? 1 : 0);
            if (i != 0) begin
                cnt = cur - fl;
                if (cnt < 1) cnt = 1;
                for (int j = 0; j < cnt; j++) begin
                    up = cur - j;
                    dn = cy - (cur - cy) + j;
                    plot_cell(cx + i, up, ch);
                    plot_cell(cx - i, up, ch);
                    plot_cell(cx + i, dn, ch);
                    plot_cell(cx - i, dn, ch);
                end
            end
            cur = rd;
        end
        plot_cell(cx, cy + r + 1, ch);
        plot_cell(cx + r + 1, cy, ch);
        plot_cell(cx, cy - r - 1, ch);
        plot_cell(cx - r - 1, cy, ch);
    endfunction

    function automatic t_rsp canvas_response(t_req r);
        t_rsp rsp;
        int xa, ya, xb, yb, reach;
        rsp.status = ST_DONE;
        rsp.cell_value = 8'd0;
        xa = int'(r.x_a);
        ya = int'(r.y_a);
        xb = int'(r.x_b);
        yb = int'(r.y_b);
        reach = int'(r.circle_reach);
        if (grid_w == 0 || grid_h == 0) begin
            rsp.status = ST_NO_GRID;
        end else begin
            case (r.req_type)
                REQ_RECT:   rect_outline(xa, ya, xb, yb, r.draw_char);
                REQ_LINE:   line_cells(xa, ya, xb, yb, r.draw_char);
                REQ_CIRCLE: circle_cells(xa, ya, reach, r.draw_char);
                default: begin
                    if (xa < 0 || ya < 0 || xa >= grid_w || ya >= grid_h)
                        rsp.status = ST_OUTSIDE;
                    else if (xa < SIDE && ya < SIDE)
                        rsp.cell_value = pix[ya*SIDE + xa];
                end
            endcase
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_req(t_req r);
        if (idle_on && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_rsp.push_back(canvas_response(r));
    endtask

    task automatic set_grid(int w, int h);
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_GRID_WIDTH;
        i_cfg_wdata <= w[10:0];
        @(posedge i_clk);
        i_cfg_idx   <= CFG_GRID_HEIGHT;
        i_cfg_wdata <= h[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        grid_w = w;
        grid_h = h;
    endtask

    function automatic t_req mk_req(t_req_kind k, int xa, int ya, int xb, int yb,
                                    int reach, int ch);
        t_req r;
        r.req_type     = k;
        r.x_a          = xa[11:0];
        r.y_a          = ya[11:0];
        r.x_b          = xb[11:0];
        r.y_b          = yb[11:0];
        r.circle_reach = reach[10:0];
        r.draw_char    = ch[7:0];
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int xa, ya, reach;
        bit wide;
        wide = $urandom_range(99) < 4;
        r.req_type = t_req_kind'($urandom_range(99) < 35 ? 3 : $urandom_range(2));
        if (wide) begin
            r.x_a = 12'($urandom); r.y_a = 12'($urandom);
            r.x_b = 12'($urandom); r.y_b = 12'($urandom);
        end else begin
            xa = $urandom_range(0, 300) - 20;
            ya = $urandom_range(0, 300) - 20;
            if (r.req_type == REQ_READ && grid_w < 300 && $urandom_range(1)) begin
                xa = $urandom_range(0, grid_w + 2) - 1;
                ya = $urandom_range(0, grid_h + 2) - 1;
            end
            r.x_a = xa[11:0];
            r.y_a = ya[11:0];
            r.x_b = 12'(xa + $urandom_range(0, 60) - 30);
            r.y_b = 12'(ya + $urandom_range(0, 60) - 30);
        end
        if (r.req_type == REQ_CIRCLE)
            reach = $urandom_range(99) < 2 ? $urandom_range(0, 1024) : $urandom_range(0, 24);
        else
            reach = $urandom_range(0, 2047);
        r.circle_reach = reach[10:0];
        r.draw_char = 8'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = 500;
            hold_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected transfer, actual status %0d value %0h",
                         $time, o_out_data.status, o_out_data.cell_value);
                errors++;
            end else begin
                exp_rsp = expected_rsp.pop_front();
                if (o_out_data.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.cell_value !== exp_rsp.cell_value) begin
                    $display("%0t: cell_value expected %0h actual %0h",
                             $time, exp_rsp.cell_value, o_out_data.cell_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d transfers outstanding", $time, expected_rsp.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_no_grid();
        send_req(mk_req(REQ_RECT, 0, 0, 5, 5, 0, 8'h41));
        send_req(mk_req(REQ_LINE, 0, 0, 9, 3, 0, 8'h42));
        send_req(mk_req(REQ_CIRCLE, 10, 10, 0, 0, 3, 8'h43));
        send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0));
        set_grid(40, 0);
        send_req(mk_req(REQ_RECT, 1, 1, 2, 2, 0, 8'h44));
        send_req(mk_req(REQ_READ, 1, 1, 0, 0, 0, 0));
    endtask

    task automatic test_shapes();
        set_grid(SIDE, SIDE);
        send_req(mk_req(REQ_RECT, 20, 15, 10, 10, 0, 8'hFF));
        send_req(mk_req(REQ_READ, 10, 10, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 15, 12, 0, 0, 0, 0));
        send_req(mk_req(REQ_RECT, 30, 30, 30, 30, 0, 8'h01));
        send_req(mk_req(REQ_RECT, -2048, -2048, 2047, 2047, 0, 8'h23));
        send_req(mk_req(REQ_LINE, 50, 90, 50, 60, 0, 8'h7C));
        send_req(mk_req(REQ_READ, 50, 75, 0, 0, 0, 0));
        send_req(mk_req(REQ_LINE, 70, 5, 40, 5, 0, 8'h2D));
        send_req(mk_req(REQ_LINE, 60, 100, 63, 140, 0, 8'h5C));
        send_req(mk_req(REQ_READ, 61, 110, 0, 0, 0, 0));
        send_req(mk_req(REQ_LINE, 90, 100, 80, 130, 0, 8'h2F));
        send_req(mk_req(REQ_LINE, -2048, 2047, 2047, -2048, 0, 8'h58));
        send_req(mk_req(REQ_CIRCLE, 128, 128, 0, 0, 0, 8'h00));
        send_req(mk_req(REQ_CIRCLE, 200, 60, 0, 0, 1, 8'h6F));
        send_req(mk_req(REQ_CIRCLE, 150, 180, 0, 0, 9, 8'h2A));
        send_req(mk_req(REQ_READ, 150, 189, 0, 0, 0, 0));
        send_req(mk_req(REQ_CIRCLE, 0, 0, 0, 0, 1024, 8'h80));
        send_req(mk_req(REQ_READ, -1, 3, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 3, -2048, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 255, 255, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 256, 0, 0, 0, 0, 0));
        set_grid(2047, 1024);
        send_req(mk_req(REQ_READ, 2046, 1023, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 2047, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_READ, 300, 10, 0, 0, 0, 0));
    endtask

    task automatic test_back_pressure();
        hold_go = 1'b1;
        repeat (20) send_req(random_req());
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (5) send_req(random_req());
    endtask

    task automatic test_random(int w, int h, int n, bit with_idle);
        set_grid(w, h);
        idle_on = with_idle;
        repeat (n) send_req(random_req());
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_GRID_WIDTH;
        i_cfg_wdata = '0;
        errors      = 0;
        cycles      = 0;
        idle_on     = 1'b1;
        hold_go     = 1'b0;
        hold_left   = 0;
        grid_w      = 0;
        grid_h      = 0;
        foreach (pix[i]) pix[i] = 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_grid();
        test_shapes();
        test_back_pressure();
        test_random(SIDE, SIDE, 300, 1'b1);
        test_random(1, 1, 200, 1'b0);
        test_random(100, 37, 250, 1'b1);
        test_random(1024, 1024, 250, 1'b1);
        test_random(300, 200, 300, 1'b1);
        test_random(2047, 2047, 300, 1'b1);

        @(posedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
